@@ src/mtsadpcm_pkg.sv @@
// Shared types, constants and lookup tables for the mono-to-stereo IMA ADPCM packer.
// No dependencies; imported by the encoder, the top level and the checker.
`timescale 1ns / 1ps

package mtsadpcm_pkg;

  typedef logic signed [15:0] pcm_t;
  typedef logic [6:0]         step_idx_t;
  typedef logic [14:0]        step_t;
  typedef logic [3:0]         code_t;
  typedef logic [7:0]         pkt_len_t;

  localparam int unsigned STEP_IDX_MAX_I = 88;
  localparam step_idx_t   STEP_IDX_MAX   = 7'(STEP_IDX_MAX_I);
  localparam pcm_t        PCM_MAX        = 16'sh7FFF;
  localparam pcm_t        PCM_MIN        = -16'sh8000;

  // Register map: word index taken from paddr[2]
  localparam logic        REG_PACKET_LENGTH = 1'b0;
  localparam pkt_len_t    PKT_LEN_RST       = 8'd240;

  localparam step_t STEP_TBL [0:STEP_IDX_MAX_I] = '{
    15'd7,     15'd8,     15'd9,     15'd10,    15'd11,    15'd12,    15'd13,    15'd14,
    15'd16,    15'd17,    15'd19,    15'd21,    15'd23,    15'd25,    15'd28,    15'd31,
    15'd34,    15'd37,    15'd41,    15'd45,    15'd50,    15'd55,    15'd60,    15'd66,
    15'd73,    15'd80,    15'd88,    15'd97,    15'd107,   15'd118,   15'd130,   15'd143,
    15'd157,   15'd173,   15'd190,   15'd209,   15'd230,   15'd253,   15'd279,   15'd307,
    15'd337,   15'd371,   15'd408,   15'd449,   15'd494,   15'd544,   15'd598,   15'd658,
    15'd724,   15'd796,   15'd876,   15'd963,   15'd1060,  15'd1166,  15'd1282,  15'd1411,
    15'd1552,  15'd1707,  15'd1878,  15'd2066,  15'd2272,  15'd2499,  15'd2749,  15'd3024,
    15'd3327,  15'd3660,  15'd4026,  15'd4428,  15'd4871,  15'd5358,  15'd5894,  15'd6484,
    15'd7132,  15'd7845,  15'd8630,  15'd9493,  15'd10442, 15'd11487, 15'd12635, 15'd13899,
    15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623, 15'd27086, 15'd29794,
    15'd32767
  };

  // Index is held in 0..88; anything above reads the top entry.
  function automatic step_t step_lookup(input step_idx_t idx);
    step_t res;
    if (idx > STEP_IDX_MAX) begin
      res = STEP_TBL[STEP_IDX_MAX_I];
    end else begin
      res = STEP_TBL[idx];
    end
    return res;
  endfunction

  // Index adjust by magnitude bits of the code (sign bit ignored)
  function automatic logic signed [7:0] idx_adjust(input logic [2:0] mag);
    logic signed [7:0] res;
    unique case (mag)
      3'd4:    res = 8'sd2;
      3'd5:    res = 8'sd4;
      3'd6:    res = 8'sd6;
      3'd7:    res = 8'sd8;
      default: res = -8'sd1;
    endcase
    return res;
  endfunction

endpackage

@@ src/mtsadpcm_enc.sv @@
// One IMA ADPCM channel encoder: predictor and step index registers plus the
// combinational quantize/update path. Depends on mtsadpcm_pkg.
`timescale 1ns / 1ps

module mtsadpcm_enc import mtsadpcm_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,       // commit state update for this sample
  input  pcm_t  sample,
  output code_t code
);

  pcm_t      pred_r, pred_nxt;
  step_idx_t idx_r,  idx_nxt;

  step_t              step;
  logic signed [16:0] diff;
  logic        [16:0] mag0, mag1, mag2;
  logic        [15:0] dq0, dq1, dq2, dq3;
  logic               neg, b2, b1, b0;
  logic signed [17:0] pred_sum;
  logic signed [7:0]  idx_sum;

  always_comb begin
    step = step_lookup(idx_r);
    diff = 17'(sample) - 17'(pred_r);
    neg  = diff[16];
    mag0 = neg ? 17'(-diff) : 17'(diff);
    dq0  = 16'(step >> 3);

    b2   = mag0 >= 17'(step);
    mag1 = b2 ? (mag0 - 17'(step)) : mag0;
    dq1  = b2 ? (dq0 + 16'(step)) : dq0;

    b1   = mag1 >= 17'(step >> 1);
    mag2 = b1 ? (mag1 - 17'(step >> 1)) : mag1;
    dq2  = b1 ? (dq1 + 16'(step >> 1)) : dq1;

    b0   = mag2 >= 17'(step >> 2);
    dq3  = b0 ? (dq2 + 16'(step >> 2)) : dq2;

    code = {neg, b2, b1, b0};

    pred_sum = neg ? (18'(pred_r) - 18'(dq3)) : (18'(pred_r) + 18'(dq3));
    priority if (pred_sum > 18'(PCM_MAX)) begin
      pred_nxt = PCM_MAX;
    end else if (pred_sum < 18'(PCM_MIN)) begin
      pred_nxt = PCM_MIN;
    end else begin
      pred_nxt = pcm_t'(pred_sum[15:0]);
    end

    idx_sum = $signed({1'b0, idx_r}) + idx_adjust(code[2:0]);
    priority if (idx_sum < 8'sd0) begin
      idx_nxt = '0;
    end else if (idx_sum > $signed({1'b0, STEP_IDX_MAX})) begin
      idx_nxt = STEP_IDX_MAX;
    end else begin
      idx_nxt = idx_sum[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pred_r <= '0;
      idx_r  <= '0;
    end else if (en) begin
      pred_r <= pred_nxt;
      idx_r  <= idx_nxt;
    end
  end

endmodule

@@ src/mono_to_stereo_ima_adpcm_packer.sv @@
// Mono-to-stereo IMA ADPCM packer: top level with input register, two channel
// encoders, packet counter, output register and APB register. Uses mtsadpcm_pkg, mtsadpcm_enc.
`timescale 1ns / 1ps

// Each transfer on the in_ channel carries one signed 16-bit mono PCM sample.
// The sample is fed to two independent IMA ADPCM encoders (left and right),
// and one byte comes out per sample on the out_ channel: right code in bits
// 7:4, left code in bits 3:0. out_last_in_packet marks the byte that
// completes each packet of packet_length bytes (register at byte address 0,
// reset 240; a value of 0 acts like 1; writing it leaves the count and the
// encoders alone, and a length lowered below the running count closes the
// packet on the next byte). Throughput is one sample per clock while the
// output is not stalled: a sample is captured in the input register, and as it
// moves on both encoders quantize it against their predictor/step-index
// registers and update them while the packed byte is loaded into the output
// register, which drives out_valid. The encoder state loop is a combinational
// path through the predictor/step-index registers, which is what sustains
// that rate. in_stall is raised only when both registers are full and the
// output is stalled.
// Configuration is written over the APB port (pready tied high); prdata
// returns packet_length for paddr[2] = 0 and zero otherwise.

module mono_to_stereo_ima_adpcm_packer import mtsadpcm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // sample input
  input  logic        in_valid,
  output logic        in_stall,
  input  pcm_t        in_mono_sample,
  // packed output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_packed_byte,
  output logic        out_last_in_packet,
  // APB register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // config register
  pkt_len_t pkt_len_r;
  logic     cfg_wr;

  // input stage
  logic     s1_vld_r, s1_vld_nxt;
  pcm_t     s1_sample_r;
  logic     in_xfer;
  logic     adv;          // s1 moves into the output register

  // output stage
  logic       out_vld_r, out_vld_nxt;
  logic [7:0] out_byte_r;
  logic       out_last_r;

  // packet counter
  pkt_len_t   cnt_r, cnt_nxt;
  pkt_len_t   len_eff;
  logic [8:0] cnt_inc;
  logic       last_nxt;

  code_t code_l, code_r;

  // --- APB ---
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_PACKET_LENGTH);
  assign prdata = (paddr[2] == REG_PACKET_LENGTH) ? {24'd0, pkt_len_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pkt_len_r <= PKT_LEN_RST;
    end else if (cfg_wr) begin
      pkt_len_r <= pwdata[7:0];
    end
  end

  // --- handshake ---
  // Output register frees up when empty or being taken this cycle.
  assign adv        = s1_vld_r && (!out_vld_r || !out_stall);
  assign in_stall   = s1_vld_r && !adv;
  assign in_xfer    = in_valid && !in_stall;
  assign s1_vld_nxt = in_xfer || (s1_vld_r && !adv);
  assign out_vld_nxt = adv || (out_vld_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_sample_r <= in_mono_sample;
    end
  end

  // --- encoders: both see the same sample, state kept per channel ---
  mtsadpcm_enc u_enc_l (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .sample (s1_sample_r),
    .code   (code_l)
  );

  mtsadpcm_enc u_enc_r (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .sample (s1_sample_r),
    .code   (code_r)
  );

  // --- packet counter ---
  always_comb begin
    len_eff = (pkt_len_r == '0) ? 8'd1 : pkt_len_r;
    cnt_inc = 9'(cnt_r) + 9'd1;
    // >= so that a length lowered mid-packet closes it right away
    last_nxt = cnt_inc >= 9'(len_eff);
    cnt_nxt  = last_nxt ? '0 : cnt_inc[7:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (adv) begin
      cnt_r <= cnt_nxt;
    end
  end

  // --- output register ---
  always_ff @(posedge clk) begin
    if (adv) begin
      out_byte_r <= {code_r, code_l};
      out_last_r <= last_nxt;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_packed_byte    = out_byte_r;
  assign out_last_in_packet = out_last_r;

endmodule

@@ src/mtsadpcm_chk.sv @@
// Port-level checker for the mono-to-stereo IMA ADPCM packer, bound to the top level.
// Depends on mono_to_stereo_ima_adpcm_packer and mtsadpcm_pkg.
`timescale 1ns / 1ps

module mtsadpcm_chk import mtsadpcm_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_packed_byte,
  input logic        out_last_in_packet,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  logic len_wr;
  assign len_wr = psel && penable && pwrite && pready && (paddr[2] == REG_PACKET_LENGTH);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_packed_byte)
                               && $stable(out_last_in_packet))
    else $error("output changed while stalled");

  // input is only held off by a full, stalled output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("in_stall without output backpressure");

  // both channels run identical encoders on the same samples
  a_nibbles_eq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_packed_byte[7:4] == out_packed_byte[3:0])
    else $error("left and right codes differ");

  // packet length readback after a write
  a_len_readback: assert property (@(posedge clk) disable iff (!rst_n)
    (len_wr && rst_n) ##1 (paddr[2] == REG_PACKET_LENGTH)
      |-> prdata[7:0] == $past(pwdata[7:0]) && prdata[31:8] == 24'd0)
    else $error("packet_length readback mismatch");

endmodule

bind mono_to_stereo_ima_adpcm_packer mtsadpcm_chk u_mtsadpcm_chk (.*);
